// ===== design/btsi_pkg.sv =====
// Shared constants and types for the B-link tree search/insert engine.
// No dependencies.
package btsi_pkg;

	typedef logic [2:0] status_t;

	localparam status_t ST_OK        = 3'd0;
	localparam status_t ST_NOT_FOUND = 3'd1;
	localparam status_t ST_EXISTS    = 3'd2;
	localparam status_t ST_NO_MEMORY = 3'd3;
	localparam status_t ST_NOT_IMPL  = 3'd4;

	localparam int IN_DATA_W  = 64;
	localparam int OUT_DATA_W = 40;
	localparam int FIELD_W    = 32;

	localparam logic OP_SEARCH = 1'b0;
	localparam logic OP_INSERT = 1'b1;

endpackage

// ===== design/btsi_ram.sv =====
// Generic single write port RAM with one registered read port.
// No dependencies.
module btsi_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== design/blink_tree_search_insert.sv =====
// B-link tree key/value engine: node rows in a key/value RAM and a link RAM, one sequencer.
// Search descends the tree node by node and then reads the leaf; insert also reads and
// writes the leaf and, per split, scans the level's region for a free node.
// One item at a time; the node RAM read port sets the pace.
// Reset: asynchronous; afterwards a clearing pass fills every node row with empty
// markers, during which no item is taken.
module blink_tree_search_insert
	import btsi_pkg::*;
#(
	parameter int ORDER           = 8,
	parameter int NODES_PER_LEVEL = 64,
	parameter int LEVELS          = 4,
	parameter int KEY_BITS        = 32,
	parameter int VALUE_BITS      = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,  // key [31:0], value [63:32]
	input  logic [0:0]            s_tuser,  // opcode [0]
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata   // status [2:0], found_value [34:3], zeros
);

	localparam int NPL        = NODES_PER_LEVEL;
	localparam int NODES      = LEVELS * NPL;
	localparam int NODE_W     = $clog2(NODES);
	localparam int LINK_W     = NODE_W + 1;
	localparam int KEEP       = (ORDER + 1) / 2;
	localparam int MOVE       = ORDER / 2;
	localparam int SLOT_W     = $clog2(ORDER);
	localparam int LVL_W      = $clog2(LEVELS);
	localparam int IDX_W      = $clog2(NPL);
	localparam int CNT_W      = $clog2(NPL + 1);
	localparam int STEP_LIMIT = NODES + LEVELS;
	localparam int STEP_W     = $clog2(STEP_LIMIT + 1);
	localparam int ROW_W      = ORDER * (KEY_BITS + VALUE_BITS);
	localparam logic [KEY_BITS-1:0] KNONE = {KEY_BITS{1'b1}};
	localparam logic [LINK_W-1:0]   LNONE = {LINK_W{1'b1}};

	localparam logic [4:0] CLR = 5'd0, IDLE = 5'd1, D_CHK = 5'd2, D_EVAL = 5'd3,
		D_DONE = 5'd4, S_RD = 5'd5, S_EV = 5'd6, I_LEAF = 5'd7, I_EV = 5'd8,
		SP_RD = 5'd9, SP_OLD = 5'd10, SP_SCAN = 5'd11, SP_WF = 5'd12, SP_WO = 5'd13,
		SP_ROOT = 5'd14, SP_NR = 5'd15, SP_P = 5'd16, SP_RET = 5'd17, M_RD = 5'd18,
		M_EV = 5'd19, P_RD = 5'd20, P_EV = 5'd21, OUT = 5'd22;

	typedef logic [ORDER-1:0][KEY_BITS-1:0]   krow_t;
	typedef logic [ORDER-1:0][VALUE_BITS-1:0] vrow_t;

	// memories
	krow_t krd, kwd;
	vrow_t vrd, vwd;
	logic [ROW_W-1:0] row_rd, row_wd;
	logic [LINK_W-1:0] lrd, lwd;
	logic [NODE_W-1:0] raddr, waddr;
	logic kwe, lwe;

	btsi_ram #(.WIDTH(ROW_W), .DEPTH(NODES)) u_rows (
		.clk(clk), .we(kwe), .waddr(waddr), .wdata(row_wd), .raddr(raddr), .rdata(row_rd));
	btsi_ram #(.WIDTH(LINK_W), .DEPTH(NODES)) u_links (
		.clk(clk), .we(lwe), .waddr(waddr), .wdata(lwd), .raddr(raddr), .rdata(lrd));

	assign row_wd = {vwd, kwd};
	assign krd    = row_rd[ORDER*KEY_BITS-1:0];
	assign vrd    = row_rd[ROW_W-1:ORDER*KEY_BITS];

	// registers
	logic [4:0]            state_q;
	logic [NODE_W-1:0]     clr_q, root_q;
	logic                  op_q, dctx_q, sctx_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [VALUE_BITS-1:0] val_q, fnd_q;
	logic [NODE_W-1:0]     path_q [LEVELS];
	logic [LEVELS-1:0]     pok_q;
	logic [LVL_W-1:0]      cur_q;
	logic [STEP_W-1:0]     steps_q;
	status_t               dst_q, sst_q, res_st_q, out_st_q;
	logic [NODE_W-1:0]     old_q, f_q, base_q, nr_q, pn_q, lf_q, pp_q;
	krow_t                 rk_q, fk_q;
	vrow_t                 rv_q, fv_q;
	logic [LINK_W-1:0]     rl_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      chk_q;
	logic                  chk_v_q, mv_q;
	logic [VALUE_BITS-1:0] res_fv_q;

	// deepest level reached
	logic [LVL_W-1:0]  dp;
	logic [NODE_W-1:0] dnode;
	always_comb begin
		dp = '0;
		for (int i = 1; i < LEVELS; i++) begin
			if (pok_q[i]) begin
				dp = LVL_W'(i);
			end
		end
		dnode = path_q[dp];
	end

	// descent step on the row just read
	logic                  d_hit, d_empty, d_child_ok;
	logic [SLOT_W-1:0]     d_idx;
	logic [VALUE_BITS-1:0] d_child;
	always_comb begin
		d_hit = 1'b0;
		d_idx = '0;
		for (int i = 0; i < ORDER; i++) begin
			if (!d_hit && (krd[i] == KNONE || key_q < krd[i])) begin
				d_hit = 1'b1;
				d_idx = SLOT_W'(i);
			end
		end
		d_empty    = krd[d_idx] == KNONE;
		d_child    = d_empty ? vrd[d_idx - 1'b1] : vrd[d_idx];
		d_child_ok = 64'(d_child) < 64'(NODES);
	end

	// leaf lookup
	logic                  s_hit;
	logic [VALUE_BITS-1:0] s_val;
	always_comb begin
		s_hit = 1'b0;
		s_val = '0;
		for (int i = 0; i < ORDER; i++) begin
			if (!s_hit && krd[i] == key_q) begin
				s_hit = 1'b1;
				s_val = vrd[i];
			end
		end
	end

	// sorted placement
	logic              p_hit, p_empty;
	logic [SLOT_W-1:0] p_e, p_at;
	krow_t             p_k;
	vrow_t             p_v;
	always_comb begin
		p_hit = 1'b0;
		p_e   = '0;
		p_at  = '0;
		for (int i = 0; i < ORDER; i++) begin
			if (!p_hit && (krd[i] == KNONE || krd[i] == key_q)) begin
				p_hit = 1'b1;
				p_e   = SLOT_W'(i);
			end
		end
		p_empty = krd[p_e] == KNONE;
		for (int j = 0; j < ORDER; j++) begin
			if (SLOT_W'(j) < p_e && krd[j] < key_q) begin
				p_at = p_at + 1'b1;
			end
		end
		p_k[0] = (p_at == '0) ? key_q : krd[0];
		p_v[0] = (p_at == '0) ? val_q : vrd[0];
		for (int j = 1; j < ORDER; j++) begin
			if (SLOT_W'(j) < p_at || SLOT_W'(j) > p_e) begin
				p_k[j] = krd[j];
				p_v[j] = vrd[j];
			end else if (SLOT_W'(j) == p_at) begin
				p_k[j] = key_q;
				p_v[j] = val_q;
			end else begin
				p_k[j] = krd[j-1];
				p_v[j] = vrd[j-1];
			end
		end
	end

	// largest key of a row
	logic [KEY_BITS-1:0] mx;
	always_comb begin
		mx = krd[0];
		for (int i = 1; i < ORDER; i++) begin
			if (krd[i] != KNONE) begin
				mx = krd[i];
			end
		end
	end

	// split rows; the new node may be the old one itself when that was empty
	logic                aliased;
	krow_t               no_k, nf_k;
	vrow_t               nf_v;
	logic [KEY_BITS-1:0] fin_old_last, fin_f_last;
	always_comb begin
		aliased = f_q == old_q;
		for (int i = 0; i < ORDER; i++) begin
			no_k[i] = (i >= KEEP) ? KNONE : rk_q[i];
		end
		for (int i = 0; i < MOVE; i++) begin
			nf_k[i] = rk_q[i + KEEP];
			nf_v[i] = rv_q[i + KEEP];
		end
		for (int i = MOVE; i < ORDER; i++) begin
			nf_k[i] = aliased ? no_k[i] : fk_q[i];
			nf_v[i] = aliased ? rv_q[i] : fv_q[i];
		end
		fin_old_last = aliased ? nf_k[KEEP-1] : no_k[KEEP-1];
		fin_f_last   = nf_k[MOVE-1];
	end

	// region base of the node being split
	logic [NODE_W-1:0] base;
	always_comb begin
		base = '0;
		for (int r = 1; r < LEVELS; r++) begin
			if ({1'b0, old_q} >= (NODE_W+1)'(r * NPL)) begin
				base = NODE_W'(r * NPL);
			end
		end
	end

	// new root index
	logic [NODE_W:0] nr;
	assign nr = ({1'b0, old_q} < (NODE_W+1)'(NPL)) ? (NODE_W+1)'(NPL)
		: {1'b0, root_q} + (NODE_W+1)'(NPL);

	// parent update after a split
	logic                pp_hit;
	logic [SLOT_W-1:0]   pp_i;
	krow_t               pp_k;
	vrow_t               pp_v;
	logic [KEY_BITS-1:0] pp_y;
	always_comb begin
		pp_hit = 1'b0;
		pp_i   = '0;
		for (int i = 0; i < ORDER; i++) begin
			if (!pp_hit && 64'(vrd[i]) == 64'(old_q)) begin
				pp_hit = 1'b1;
				pp_i   = SLOT_W'(i);
			end
		end
		pp_k[0] = (pp_i == '0) ? fin_old_last : krd[0];
		pp_v[0] = vrd[0];
		for (int j = 1; j < ORDER; j++) begin
			if (SLOT_W'(j) < pp_i) begin
				pp_k[j] = krd[j];
				pp_v[j] = vrd[j];
			end else if (SLOT_W'(j) == pp_i) begin
				pp_k[j] = fin_old_last;
				pp_v[j] = vrd[j];
			end else begin
				pp_k[j] = krd[j-1];
				pp_v[j] = vrd[j-1];
			end
		end
		// the separator of the new node is read after the shift
		pp_y = (pp_q == f_q) ? pp_k[MOVE-1] : fin_f_last;
		for (int j = 1; j < ORDER; j++) begin
			if (SLOT_W'(j) == pp_i + 1'b1 && SLOT_W'(j) > pp_i) begin
				pp_k[j] = pp_y;
				pp_v[j] = VALUE_BITS'(f_q);
			end
		end
	end

	// RAM ports
	always_comb begin
		raddr = old_q;
		unique case (state_q)
			D_CHK:   raddr = path_q[cur_q];
			S_RD:    raddr = dnode;
			I_LEAF:  raddr = dnode;
			SP_SCAN: raddr = base_q + NODE_W'(cnt_q);
			SP_ROOT: raddr = (root_q == old_q) ? nr[NODE_W-1:0] : path_q[dp - 1'b1];
			M_RD:    raddr = lf_q;
			P_RD:    raddr = pn_q;
			default: raddr = old_q;
		endcase
	end

	always_comb begin
		kwe   = 1'b0;
		lwe   = 1'b0;
		waddr = old_q;
		kwd   = no_k;
		vwd   = nf_v;
		lwd   = NODE_W'(f_q);
		unique case (state_q)
			CLR: begin
				kwe = 1'b1; lwe = 1'b1;
				waddr = clr_q;
				kwd = '1; vwd = '1; lwd = LNONE;
			end
			SP_WF: begin
				kwe = 1'b1; lwe = 1'b1;
				waddr = f_q;
				kwd = nf_k; vwd = nf_v; lwd = rl_q;
			end
			SP_WO: begin
				kwe = !aliased; lwe = 1'b1;
				waddr = old_q;
				kwd = no_k; vwd = rv_q; lwd = LINK_W'(f_q);
			end
			SP_NR: begin
				kwe = 1'b1;
				waddr = nr_q;
				kwd = '1; vwd = vrd;
				kwd[0] = fin_old_last;
				kwd[1] = fin_f_last;
				vwd[0] = VALUE_BITS'(old_q);
				vwd[1] = VALUE_BITS'(f_q);
			end
			SP_P: begin
				kwe = krd[ORDER-1] == KNONE && pp_hit;
				waddr = pp_q;
				kwd = pp_k; vwd = pp_v;
			end
			P_EV: begin
				kwe = p_hit && p_empty;
				waddr = pn_q;
				kwd = p_k; vwd = p_v;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CLR;
			clr_q   <= '0;
			root_q  <= '0;
			mv_q    <= 1'b0;
			pok_q   <= '0;
			cur_q   <= '0;
		end else begin
			if (state_q == OUT && (!mv_q || m_tready)) begin
				mv_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				mv_q <= 1'b0;
			end
			unique case (state_q)
				CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == NODE_W'(NODES - 1)) begin
						state_q <= IDLE;
					end
				end
				IDLE: begin
					if (s_tvalid) begin
						op_q       <= s_tuser[0];
						key_q      <= KEY_BITS'(s_tdata[FIELD_W-1:0]);
						val_q      <= VALUE_BITS'(s_tdata[2*FIELD_W-1:FIELD_W]);
						fnd_q      <= '0;
						dctx_q     <= 1'b0;
						pok_q      <= LEVELS'(1);
						path_q[0]  <= root_q;
						cur_q      <= '0;
						steps_q    <= '0;
						state_q    <= D_CHK;
					end
				end
				D_CHK: begin
					if ({1'b0, path_q[cur_q]} < (NODE_W+1)'(NPL)) begin
						dst_q   <= ST_OK;
						state_q <= D_DONE;
					end else if (steps_q == STEP_W'(STEP_LIMIT)) begin
						dst_q   <= ST_NOT_FOUND;
						state_q <= D_DONE;
					end else begin
						steps_q <= steps_q + 1'b1;
						state_q <= D_EVAL;
					end
				end
				D_EVAL: begin
					state_q <= D_CHK;
					if (d_hit) begin
						if ((d_empty && d_idx == '0) || cur_q == LVL_W'(LEVELS - 1)
								|| !d_child_ok) begin
							dst_q   <= ST_NOT_FOUND;
							state_q <= D_DONE;
						end else begin
							cur_q <= cur_q + 1'b1;
							path_q[cur_q + 1'b1] <= NODE_W'(d_child);
							pok_q[cur_q + 1'b1]  <= 1'b1;
						end
					end else if ({1'b0, lrd} >= (LINK_W+1)'(NODES)) begin
						dst_q   <= ST_NOT_FOUND;
						state_q <= D_DONE;
					end else begin
						path_q[cur_q] <= NODE_W'(lrd);
					end
				end
				D_DONE: begin
					if (dctx_q) begin
						state_q <= I_LEAF;
					end else if (op_q == OP_SEARCH) begin
						if (dst_q == ST_OK) begin
							state_q <= S_RD;
						end else begin
							res_st_q <= ST_NOT_FOUND;
							state_q  <= OUT;
						end
					end else if (dst_q == ST_NOT_FOUND) begin
						old_q   <= dnode;
						sctx_q  <= 1'b0;
						state_q <= SP_RD;
					end else begin
						state_q <= I_LEAF;
					end
				end
				S_RD: state_q <= S_EV;
				S_EV: begin
					res_st_q <= s_hit ? ST_OK : ST_NOT_FOUND;
					fnd_q    <= s_hit ? s_val : '0;
					state_q  <= OUT;
				end
				I_LEAF: begin
					lf_q    <= dnode;
					state_q <= I_EV;
				end
				I_EV: begin
					if (krd[ORDER-1] != KNONE) begin
						old_q   <= lf_q;
						sctx_q  <= 1'b1;
						state_q <= SP_RD;
					end else begin
						pn_q    <= lf_q;
						state_q <= P_RD;
					end
				end
				SP_RD: state_q <= SP_OLD;
				SP_OLD: begin
					rk_q    <= krd;
					rv_q    <= vrd;
					rl_q    <= lrd;
					base_q  <= base;
					cnt_q   <= '0;
					chk_v_q <= 1'b0;
					state_q <= SP_SCAN;
				end
				SP_SCAN: begin
					// one row address issued per cycle, its row checked in the following cycle
					chk_v_q <= cnt_q < CNT_W'(NPL);
					chk_q   <= IDX_W'(cnt_q);
					cnt_q   <= cnt_q + 1'b1;
					if (chk_v_q && krd[0] == KNONE) begin
						f_q     <= base_q + NODE_W'(chk_q);
						fk_q    <= krd;
						fv_q    <= vrd;
						state_q <= SP_WF;
					end else if (chk_v_q && chk_q == IDX_W'(NPL - 1)) begin
						sst_q   <= ST_NO_MEMORY;
						state_q <= SP_RET;
					end
				end
				SP_WF: state_q <= SP_WO;
				SP_WO: state_q <= SP_ROOT;
				SP_ROOT: begin
					if (root_q == old_q) begin
						if (nr >= (NODE_W+1)'(NODES)) begin
							sst_q   <= ST_NOT_IMPL;
							state_q <= SP_RET;
						end else begin
							nr_q    <= nr[NODE_W-1:0];
							state_q <= SP_NR;
						end
					end else if (dp == '0) begin
						sst_q   <= ST_NOT_IMPL;
						state_q <= SP_RET;
					end else begin
						pp_q    <= path_q[dp - 1'b1];
						state_q <= SP_P;
					end
				end
				SP_NR: begin
					root_q  <= nr_q;
					sst_q   <= ST_OK;
					state_q <= SP_RET;
				end
				SP_P: begin
					sst_q   <= (krd[ORDER-1] == KNONE && pp_hit) ? ST_OK : ST_NOT_IMPL;
					state_q <= SP_RET;
				end
				SP_RET: begin
					if (!sctx_q) begin
						// descend again after the forced split
						dctx_q    <= 1'b1;
						path_q[0] <= root_q;
						pok_q[0]  <= 1'b1;
						cur_q     <= '0;
						steps_q   <= '0;
						state_q   <= D_CHK;
					end else if (sst_q == ST_OK) begin
						state_q <= M_RD;
					end else begin
						res_st_q <= sst_q;
						state_q  <= OUT;
					end
				end
				M_RD: state_q <= M_EV;
				M_EV: begin
					if (key_q < mx) begin
						pn_q    <= lf_q;
						state_q <= P_RD;
					end else if ({1'b0, lrd} < (LINK_W+1)'(NODES)) begin
						pn_q    <= NODE_W'(lrd);
						state_q <= P_RD;
					end else begin
						res_st_q <= ST_NOT_IMPL;
						state_q  <= OUT;
					end
				end
				P_RD: state_q <= P_EV;
				P_EV: begin
					if (!p_hit) begin
						res_st_q <= ST_NO_MEMORY;
					end else if (!p_empty) begin
						res_st_q <= ST_EXISTS;
					end else begin
						res_st_q <= ST_OK;
					end
					state_q <= OUT;
				end
				OUT: begin
					// result held in its own register while the next item is worked on
					if (!mv_q || m_tready) begin
						res_fv_q <= fnd_q;
						out_st_q <= res_st_q;
						state_q  <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign s_tready = state_q == IDLE;
	assign m_tvalid = mv_q;
	assign m_tdata  = {5'b0, FIELD_W'(res_fv_q), out_st_q};

	// checks
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, root_q} < (NODE_W+1)'(NODES))
		else $error("root node outside node memory");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, cur_q} < (LVL_W+1)'(LEVELS))
		else $error("descent level out of range");

	a_no_early_result: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !$rose(m_tvalid))
		else $error("result raised in the cycle after an item was taken");

	a_free_in_region: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SP_WF) |-> (f_q >= base_q))
		else $error("free node taken below its region");

endmodule
